/* hw/rtl/dmc_pkg.sv */
// ----------------------------------------------------------------------------
// dmc_pkg
// Types and constants shared by the direct-mapped write-back cache unit.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int LINE_BYTES = 64;
	localparam int NUM_LINES  = 8;
	localparam int ADDR_BITS  = 12;
	localparam int OFF_W      = $clog2(LINE_BYTES);
	localparam int IDX_W      = $clog2(NUM_LINES);
	localparam int TAG_W      = ADDR_BITS - OFF_W - IDX_W;
	localparam int LADDR_W    = IDX_W + OFF_W;
	localparam int MEM_DEPTH  = 1 << ADDR_BITS;

	typedef enum logic [1:0] {
		REQ_READ    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_FLUSH   = 2'd2,
		REQ_PRELOAD = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_FILL,
		ST_ACCESS,
		ST_FL_SCAN,
		ST_FL_WB,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic latch;
		logic clr_step;
		logic lookup;
		logic copy_wb;
		logic copy_fill;
		logic access;
		logic fl_next;
		logic fl_line_done;
		logic respond;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic hit;
		logic victim_dirty;
		logic fl_dirty;
		logic fl_last;
		logic copy_done;
		logic clr_last;
	} sts_t;

endpackage

/* hw/rtl/dmc_ctrl.sv */
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer for lookups, line copies, flush scans and the reset clearing pass.
// ----------------------------------------------------------------------------
module dmc_ctrl import dmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				case (sts.req)
					REQ_READ, REQ_WRITE: begin
						if (sts.hit) state_d = ST_RESP;
						else if (sts.victim_dirty) state_d = ST_WB;
						else state_d = ST_FILL;
					end
					REQ_FLUSH: state_d = ST_FL_SCAN;
					default: state_d = ST_RESP;
				endcase
			end
			ST_WB: begin
				if (sts.copy_done) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (sts.copy_done) state_d = ST_ACCESS;
			end
			ST_ACCESS: state_d = ST_RESP;
			ST_FL_SCAN: begin
				if (sts.fl_dirty) state_d = ST_FL_WB;
				else if (sts.fl_last) state_d = ST_RESP;
			end
			ST_FL_WB: begin
				if (sts.copy_done) state_d = sts.fl_last ? ST_RESP : ST_FL_SCAN;
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_WB: cmd.copy_wb = 1'b1;
			ST_FILL: cmd.copy_fill = 1'b1;
			ST_ACCESS: cmd.access = 1'b1;
			ST_FL_SCAN: begin
				cmd.fl_next = !sts.fl_dirty && !sts.fl_last;
			end
			ST_FL_WB: begin
				cmd.copy_wb      = 1'b1;
				cmd.fl_line_done = sts.copy_done;
				cmd.fl_next      = sts.copy_done && !sts.fl_last;
			end
			ST_RESP: cmd.respond = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

/* hw/rtl/dmc_datapath.sv */
// ----------------------------------------------------------------------------
// dmc_datapath
// Line store, backing memory, tag and state bits, copy engine and counters.
// ----------------------------------------------------------------------------
module dmc_datapath import dmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] address,
	input  logic [7:0]           write_data,
	output sts_t                 sts,
	output logic                 done,
	output logic [7:0]           read_data,
	output logic                 hit,
	output logic                 wrote_back,
	output logic [ADDR_BITS-1:0] victim_line_addr,
	output logic [3:0]           lines_flushed,
	output logic [31:0]          hit_total,
	output logic [31:0]          miss_total
);

	logic [7:0] line_mem [1 << LADDR_W];
	logic [7:0] back_mem [MEM_DEPTH];

	req_t                 req_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           wdata_q;
	logic [TAG_W-1:0]     tag_q [NUM_LINES];
	logic [NUM_LINES-1:0] valid_q;
	logic [NUM_LINES-1:0] dirty_q;
	logic [IDX_W-1:0]     fidx_q;
	logic [IDX_W:0]       flushed_q;
	logic [OFF_W:0]       cnt_q;
	logic [OFF_W-1:0]     off_s1;
	logic                 vld_s1;
	logic                 wb_s1;
	logic [7:0]           line_rd_q;
	logic [7:0]           back_rd_q;
	logic [ADDR_BITS-1:0] clr_cnt_q;
	logic [31:0]          hits_q;
	logic [31:0]          misses_q;
	logic                 done_q;
	logic [7:0]           rdata_q;
	logic                 hit_q;
	logic                 wb_q;
	logic [ADDR_BITS-1:0] victim_q;

	logic [OFF_W-1:0]     off;
	logic [IDX_W-1:0]     idx;
	logic [TAG_W-1:0]     tag;
	logic [IDX_W-1:0]     cur_idx;
	logic                 rw;
	logic                 lk_hit;
	logic                 vdirty;
	logic                 copying;
	logic                 copy_rd;
	logic [ADDR_BITS-1:0] vbase;
	logic [ADDR_BITS-1:0] nbase;
	logic                 line_we;
	logic [LADDR_W-1:0]   line_wa;
	logic [7:0]           line_wd;
	logic [LADDR_W-1:0]   line_ra;
	logic                 back_we;
	logic [ADDR_BITS-1:0] back_wa;
	logic [7:0]           back_wd;
	logic                 acc_wr;

	assign off     = addr_q[OFF_W-1:0];
	assign idx     = addr_q[OFF_W +: IDX_W];
	assign tag     = addr_q[ADDR_BITS-1 -: TAG_W];
	assign cur_idx = (req_q == REQ_FLUSH) ? fidx_q : idx;
	assign rw      = (req_q == REQ_READ) || (req_q == REQ_WRITE);
	assign lk_hit  = valid_q[idx] && (tag_q[idx] == tag);
	assign vdirty  = valid_q[idx] && dirty_q[idx];
	assign copying = cmd.copy_wb || cmd.copy_fill;
	assign copy_rd = copying && !cnt_q[OFF_W];
	assign vbase   = {tag_q[cur_idx], cur_idx, {OFF_W{1'b0}}};
	assign nbase   = {tag, idx, {OFF_W{1'b0}}};

	assign sts.req          = req_q;
	assign sts.hit          = lk_hit;
	assign sts.victim_dirty = vdirty;
	assign sts.fl_dirty     = valid_q[fidx_q] && dirty_q[fidx_q];
	assign sts.fl_last      = fidx_q == IDX_W'(NUM_LINES - 1);
	assign sts.copy_done    = cnt_q == (OFF_W+1)'(LINE_BYTES);
	assign sts.clr_last     = &clr_cnt_q;

	assign acc_wr = (req_q == REQ_WRITE) && ((cmd.lookup && lk_hit) || cmd.access);

	always_comb begin
		line_we = 1'b0;
		line_wa = {idx, off};
		line_wd = wdata_q;
		if (vld_s1 && !wb_s1) begin
			line_we = 1'b1;
			line_wa = {idx, off_s1};
			line_wd = back_rd_q;
		end else if (acc_wr) begin
			line_we = 1'b1;
		end
	end

	assign line_ra = cmd.copy_wb ? {cur_idx, cnt_q[OFF_W-1:0]} : {idx, off};

	always_comb begin
		back_we = 1'b0;
		back_wa = addr_q;
		back_wd = wdata_q;
		if (cmd.clr_step) begin
			back_we = 1'b1;
			back_wa = clr_cnt_q;
			back_wd = 8'd0;
		end else if (vld_s1 && wb_s1) begin
			back_we = 1'b1;
			back_wa = vbase | ADDR_BITS'(off_s1);
			back_wd = line_rd_q;
		end else if (cmd.lookup && (req_q == REQ_PRELOAD)) begin
			back_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_wa] <= line_wd;
		line_rd_q <= line_mem[line_ra];
	end

	always_ff @(posedge clk) begin
		if (back_we) back_mem[back_wa] <= back_wd;
		back_rd_q <= back_mem[nbase | ADDR_BITS'(cnt_q[OFF_W-1:0])];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q   <= req_t'(req_type);
			addr_q  <= address;
			wdata_q <= write_data;
		end
		off_s1 <= cnt_q[OFF_W-1:0];
		wb_s1  <= cmd.copy_wb;
		if (cmd.respond) rdata_q <= (req_q == REQ_READ) ? line_rd_q : 8'd0;
		if (cmd.lookup) begin
			hit_q    <= rw && lk_hit;
			wb_q     <= rw && !lk_hit && vdirty;
			victim_q <= (rw && !lk_hit && vdirty) ? vbase : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) tag_q[i] <= '0;
			valid_q   <= '0;
			dirty_q   <= '0;
			fidx_q    <= '0;
			flushed_q <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			clr_cnt_q <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			vld_s1 <= copy_rd;
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (copying) cnt_q <= sts.copy_done ? '0 : cnt_q + 1'b1;
			if (cmd.lookup) begin
				fidx_q    <= '0;
				flushed_q <= '0;
				if (rw) begin
					if (lk_hit) begin
						if (hits_q != '1) hits_q <= hits_q + 1'b1;
					end else if (misses_q != '1) begin
						misses_q <= misses_q + 1'b1;
					end
				end
			end
			if (cmd.fl_next) fidx_q <= fidx_q + 1'b1;
			if (cmd.fl_line_done) begin
				dirty_q[fidx_q] <= 1'b0;
				flushed_q       <= flushed_q + 1'b1;
			end
			if (cmd.access) begin
				tag_q[idx]   <= tag;
				valid_q[idx] <= 1'b1;
				dirty_q[idx] <= req_q == REQ_WRITE;
			end else if (cmd.lookup && lk_hit && (req_q == REQ_WRITE)) begin
				dirty_q[idx] <= 1'b1;
			end
		end
	end

	assign done             = done_q;
	assign read_data        = rdata_q;
	assign hit              = hit_q;
	assign wrote_back       = wb_q;
	assign victim_line_addr = victim_q;
	assign lines_flushed    = 4'(flushed_q);
	assign hit_total        = hits_q;
	assign miss_total       = misses_q;

endmodule

/* hw/rtl/direct_mapped_writeback_cache_unit.sv */
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_unit
// Direct-mapped write-back, write-allocate byte cache with its own backing
// memory, hit and miss counters.
// ----------------------------------------------------------------------------
//   Channel   Handshake            Ports
//   request   start & !busy        req_type, address, write_data
//   result    done, one cycle      read_data, hit, wrote_back,
//                                  victim_line_addr, lines_flushed,
//                                  hit_total, miss_total
//
// A hit or a preload goes from the lookup straight to the done strobe. A miss adds
// the line fill and the access after it, and before them a write-back when a dirty
// victim is written back. A flush scans every line and writes back each dirty one.
// Copies move one byte a cycle between the line store and the backing memory.
// After reset the backing memory is cleared with busy high.
// The receiver cannot stall; one word is delivered per accepted request.
module direct_mapped_writeback_cache_unit import dmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] address,
	input  logic [7:0]           write_data,
	output logic                 done,
	output logic [7:0]           read_data,
	output logic                 hit,
	output logic                 wrote_back,
	output logic [ADDR_BITS-1:0] victim_line_addr,
	output logic [3:0]           lines_flushed,
	output logic [31:0]          hit_total,
	output logic [31:0]          miss_total
);

	cmd_t cmd;
	sts_t sts;

	dmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dmc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.req_type         (req_type),
		.address          (address),
		.write_data       (write_data),
		.sts              (sts),
		.done             (done),
		.read_data        (read_data),
		.hit              (hit),
		.wrote_back       (wrote_back),
		.victim_line_addr (victim_line_addr),
		.lines_flushed    (lines_flushed),
		.hit_total        (hit_total),
		.miss_total       (miss_total)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accept not followed by busy");
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !wrote_back) else $error("write-back reported on a hit");
	a_victim_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && wrote_back |-> victim_line_addr[OFF_W-1:0] == '0)
		else $error("victim address not line aligned");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Direct-mapped write-back cache unit testbench
// Drives reads, writes, flushes and preloads through the start/busy port and
// checks every done word against a behavioral cache and memory model.
// ----------------------------------------------------------------------------
module tb;
	import dmc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]  rdata;
		logic        hit;
		logic        wb;
		logic [11:0] victim;
		logic [3:0]  flushed;
		logic [31:0] hits;
		logic [31:0] misses;
	} cache_word_t;

	typedef struct {
		req_t        req;
		logic [11:0] addr;
		logic [7:0]  wdata;
		logic        typed;
		cache_word_t want;
	} dir_row_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] req_type;
	logic [11:0] address;
	logic [7:0] write_data;
	logic [7:0] read_data;
	logic hit, wrote_back;
	logic [11:0] victim_line_addr;
	logic [3:0] lines_flushed;
	logic [31:0] hit_total, miss_total;

	direct_mapped_writeback_cache_unit u_top (.*);

	logic [7:0] mdl_lines [NUM_LINES][LINE_BYTES];
	logic [TAG_W-1:0] mdl_tag [NUM_LINES];
	logic mdl_valid [NUM_LINES];
	logic mdl_dirty [NUM_LINES];
	logic [7:0] mdl_mem [MEM_DEPTH];
	logic [31:0] mdl_hits, mdl_misses;
	cache_word_t pending_words[$];
	int mismatches, word_count, sent;
	int send_idle;
	int n_hit, n_wb, n_flush;

	function automatic void write_line_back(int idx);
		logic [11:0] base;
		base = {mdl_tag[idx], idx[IDX_W-1:0], {OFF_W{1'b0}}};
		for (int k = 0; k < LINE_BYTES; k++) mdl_mem[base + k] = mdl_lines[idx][k];
	endfunction

	function automatic cache_word_t cache_access(req_t r, logic [11:0] a, logic [7:0] d);
		cache_word_t w;
		int off, idx;
		logic [TAG_W-1:0] tg;
		w = '{default: '0};
		off = a[OFF_W-1:0];
		idx = a[OFF_W +: IDX_W];
		tg = a[11 -: TAG_W];
		if (r == REQ_READ || r == REQ_WRITE) begin
			if (mdl_valid[idx] && mdl_tag[idx] == tg) begin
				w.hit = 1;
				if (mdl_hits != '1) mdl_hits++;
			end else begin
				if (mdl_valid[idx] && mdl_dirty[idx]) begin
					w.victim = {mdl_tag[idx], idx[IDX_W-1:0], {OFF_W{1'b0}}};
					write_line_back(idx);
					w.wb = 1;
				end
				if (mdl_misses != '1) mdl_misses++;
				for (int k = 0; k < LINE_BYTES; k++)
					mdl_lines[idx][k] = mdl_mem[{a[11:OFF_W], {OFF_W{1'b0}}} + k];
				mdl_valid[idx] = 1;
				mdl_dirty[idx] = 0;
				mdl_tag[idx] = tg;
			end
			if (r == REQ_READ) w.rdata = mdl_lines[idx][off];
			else begin
				mdl_lines[idx][off] = d;
				mdl_dirty[idx] = 1;
			end
		end else if (r == REQ_FLUSH) begin
			for (int i = 0; i < NUM_LINES; i++)
				if (mdl_valid[i] && mdl_dirty[i]) begin
					write_line_back(i);
					mdl_dirty[i] = 0;
					w.flushed++;
				end
		end else mdl_mem[a] = d;
		w.hits = mdl_hits;
		w.misses = mdl_misses;
		return w;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL direct_mapped_writeback_cache_unit");
		$finish;
	end

	always @(posedge clk) begin
		cache_word_t w;
		if (done) begin
			word_count++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
			end else begin
				w = pending_words.pop_front();
				if (read_data !== w.rdata || hit !== w.hit || wrote_back !== w.wb ||
				    victim_line_addr !== w.victim || lines_flushed !== w.flushed ||
				    hit_total !== w.hits || miss_total !== w.misses) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp rd=%h h=%b wb=%b v=%h f=%0d ht=%0d mt=%0d",
							w.rdata, w.hit, w.wb, w.victim, w.flushed, w.hits, w.misses);
						$display("          got rd=%h h=%b wb=%b v=%h f=%0d ht=%0d mt=%0d",
							read_data, hit, wrote_back, victim_line_addr, lines_flushed,
							hit_total, miss_total);
					end
				end
				n_hit += w.hit;
				n_wb += w.wb;
				n_flush += (w.flushed != 0);
			end
		end
	end

	task automatic send_word(req_t r, logic [11:0] a, logic [7:0] d, logic typed,
	                         cache_word_t want);
		cache_word_t w;
		while ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= r;
		address <= a;
		write_data <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		w = cache_access(r, a, d);
		if (typed) w = want;
		pending_words.push_back(w);
		sent++;
	endtask

	function automatic logic [11:0] pick_addr();
		logic [11:0] a;
		a = 12'($urandom);
		if ($urandom_range(3) != 0) a[11:OFF_W + IDX_W] = TAG_W'($urandom_range(1));
		return a;
	endfunction

	dir_row_t dir_rows [$];
	cache_word_t z;

	initial begin
		req_t r;
		int roll;
		start = 0;
		req_type = 0;
		address = 0;
		write_data = 0;
		arst_n = 0;
		mismatches = 0;
		word_count = 0;
		sent = 0;
		send_idle = 0;
		n_hit = 0;
		n_wb = 0;
		n_flush = 0;
		mdl_hits = 0;
		mdl_misses = 0;
		for (int i = 0; i < NUM_LINES; i++) begin
			mdl_valid[i] = 0;
			mdl_dirty[i] = 0;
			mdl_tag[i] = 0;
			for (int k = 0; k < LINE_BYTES; k++) mdl_lines[i][k] = 0;
		end
		for (int i = 0; i < MEM_DEPTH; i++) mdl_mem[i] = 0;
		z = '{default: '0};
		dir_rows.push_back('{REQ_READ, 12'h000, 8'h00, 1'b1,
			'{8'h00, 1'b0, 1'b0, 12'h0, 4'd0, 32'd0, 32'd1}});
		dir_rows.push_back('{REQ_FLUSH, 12'h000, 8'h00, 1'b1,
			'{8'h00, 1'b0, 1'b0, 12'h0, 4'd0, 32'd0, 32'd1}});
		dir_rows.push_back('{REQ_PRELOAD, 12'hFFF, 8'hFF, 1'b1,
			'{8'h00, 1'b0, 1'b0, 12'h0, 4'd0, 32'd0, 32'd1}});
		dir_rows.push_back('{REQ_READ, 12'hFFF, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_WRITE, 12'hFFE, 8'hA5, 1'b0, z});
		dir_rows.push_back('{REQ_WRITE, 12'h000, 8'hFF, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'h000, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_PRELOAD, 12'h001, 8'h5A, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'h001, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'h200, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'h001, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_WRITE, 12'h7C0, 8'h3C, 1'b0, z});
		dir_rows.push_back('{REQ_WRITE, 12'h155, 8'hC3, 1'b0, z});
		dir_rows.push_back('{REQ_FLUSH, 12'hFFF, 8'hFF, 1'b0, z});
		dir_rows.push_back('{REQ_FLUSH, 12'h000, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'hE3F, 8'h00, 1'b0, z});
		dir_rows.push_back('{REQ_READ, 12'hFFE, 8'h00, 1'b0, z});
		repeat (2) @(posedge clk);
		arst_n <= 1;
		foreach (dir_rows[i])
			send_word(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].wdata,
				dir_rows[i].typed, dir_rows[i].want);
		for (int n = 0; n < 1350; n++) begin
			send_idle = (n < 450) ? 29 : (n < 900) ? 47 : 0;
			if (n == 700) begin
				start <= 1'b0;
				while (pending_words.size() != 0) @(posedge clk);
			end
			roll = $urandom_range(99);
			r = roll < 45 ? REQ_READ : roll < 85 ? REQ_WRITE : roll < 92 ? REQ_FLUSH
				: REQ_PRELOAD;
			send_word(r, pick_addr(), 8'($urandom), 1'b0, z);
		end
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		$display("Sent %0d requests, %0d words back: %0d hits, %0d write-backs, %0d flushes.",
			sent, word_count, n_hit, n_wb, n_flush);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("PASS direct_mapped_writeback_cache_unit");
		else
			$display("FAIL direct_mapped_writeback_cache_unit");
		$finish;
	end
endmodule
